@@ design/upa_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// upa_pkg
// Types and constants shared by the proximity alarm lanes, the merging stage
// and the top level.
// ---------------------------------------------------------------------------
package upa_pkg;

    // Field widths of the stream items and the registers.
    localparam int unsigned CAPTURE_W = 16;
    localparam int unsigned CM_W      = 10;
    localparam int unsigned TONE_W    = 3;
    localparam int unsigned TICKS_W   = 16;
    localparam int unsigned COUNT_W   = 17;

    // floor(w / 58) for w below 2^15 as (w * CM_RECIP) >> CM_SHIFT.
    // The reciprocal is rounded up; its error of 12 times w stays below 2^21.
    localparam int unsigned CM_SHIFT = 21;
    localparam logic [15:0] CM_RECIP = 16'd36158;

    // Tone bands in centimetres.
    localparam logic [CM_W-1:0] BAND_1 = 10'd30;
    localparam logic [CM_W-1:0] BAND_2 = 10'd20;
    localparam logic [CM_W-1:0] BAND_3 = 10'd15;
    localparam logic [CM_W-1:0] BAND_4 = 10'd10;
    localparam logic [CM_W-1:0] BAND_5 = 10'd5;

    // Tone levels that beep in the window.
    localparam logic [TONE_W-1:0] TONE_BEEP_LO = 3'd1;
    localparam logic [TONE_W-1:0] TONE_BEEP_HI = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [TICKS_W-1:0] WINDOW_TICKS_RST = 16'd1200;
    localparam logic [CM_W-1:0]    ALARM_CM_RST     = 10'd5;

    // Register indexes of the configuration port.
    localparam logic CFG_WINDOW_TICKS = 1'b0;
    localparam logic CFG_ALARM_CM     = 1'b1;

    // Kinds of input item.
    typedef enum logic [1:0] {
        REQ_MEASURE = 2'd0,
        REQ_TICK    = 2'd1,
        REQ_STOP    = 2'd2
    } t_req;

    // What one sensor lane found for a measure item.
    typedef struct packed {
        logic [CM_W-1:0]   cm;
        logic              alarm;
        logic [TONE_W-1:0] tone;
    } t_lane_res;

    // Configuration as seen by the merging stage.
    typedef struct packed {
        logic [TICKS_W-1:0] window_ticks;
    } t_merge_cfg;

    // One result item, last field in the lowest bits.
    typedef struct packed {
        logic              window_done;
        logic [TONE_W-1:0] tone_level;
        logic              buzzer_on;
        logic              alert_front;
        logic              alert_back;
        logic [CM_W-1:0]   dist_front_cm;
        logic [CM_W-1:0]   dist_back_cm;
    } t_result;

endpackage
`default_nettype wire

@@ design/upa_echo_lane.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// upa_echo_lane
// One sensor lane: echo width, centimetres, alarm flag and tone band,
// registered when the pipeline takes an item.
// ---------------------------------------------------------------------------
module upa_echo_lane
    import upa_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_load,
    input  wire logic [CAPTURE_W-1:0] i_rise,
    input  wire logic [CAPTURE_W-1:0] i_fall,
    input  wire logic [CM_W-1:0]      i_alarm_cm,
    output t_lane_res                 o_res
);

    logic [CAPTURE_W-1:0] w_width;
    logic [31:0]          w_prod;
    logic [CM_W-1:0]      w_cm;
    logic [TONE_W-1:0]    w_tone;
    t_lane_res            r_res;

    // Echo width modulo 2^16, halved, then divided by 58 via the reciprocal.
    assign w_width = i_fall - i_rise;
    assign w_prod  = {17'd0, w_width[CAPTURE_W-1:1]} * {16'd0, CM_RECIP};
    assign w_cm    = w_prod[CM_SHIFT+CM_W-1:CM_SHIFT];

    // Tone band of the distance.
    always_comb begin
        if (w_cm >= BAND_1) begin
            w_tone = 3'd0;
        end else if (w_cm >= BAND_2) begin
            w_tone = 3'd1;
        end else if (w_cm >= BAND_3) begin
            w_tone = 3'd2;
        end else if (w_cm >= BAND_4) begin
            w_tone = 3'd3;
        end else if (w_cm >= BAND_5) begin
            w_tone = 3'd4;
        end else begin
            w_tone = 3'd5;
        end
    end

    // Lane result register.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res.cm    <= w_cm;
            r_res.alarm <= (w_cm < i_alarm_cm);
            r_res.tone  <= w_tone;
        end
    end

    assign o_res = r_res;

endmodule
`default_nettype wire

@@ design/upa_merge.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// upa_merge
// Merging stage: folds the two lane results into the stored distances,
// alarms and tones, runs the beep window and registers the result item.
// ---------------------------------------------------------------------------
module upa_merge
    import upa_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_advance,
    input  wire logic [1:0] i_req,
    input  wire t_lane_res  i_back,
    input  wire t_lane_res  i_front,
    input  wire t_merge_cfg i_cfg,
    output t_result         o_result
);

    logic [CM_W-1:0]    r_bd, n_bd, r_fd, n_fd;
    logic [TONE_W-1:0]  r_bt, n_bt, r_ft, n_ft;
    logic               r_ba, n_ba, r_fa, n_fa;
    logic               r_alb, n_alb, r_alf, n_alf;
    logic               r_buz, n_buz;
    logic               r_wa, n_wa;
    logic [COUNT_W-1:0] r_wc, n_wc, r_bc, n_bc;
    t_result            r_out, n_out;

    logic               w_bch, w_fch, w_done, w_check;
    logic [TONE_W-1:0]  w_lvl;
    logic [TICKS_W-1:0] w_period;

    // State update for one item.
    always_comb begin
        n_bd    = r_bd;
        n_fd    = r_fd;
        n_bt    = r_bt;
        n_ft    = r_ft;
        n_ba    = r_ba;
        n_fa    = r_fa;
        n_alb   = r_alb;
        n_alf   = r_alf;
        n_buz   = r_buz;
        n_wa    = r_wa;
        n_wc    = r_wc;
        n_bc    = r_bc;
        w_done  = 1'b0;
        w_check = 1'b0;
        w_bch   = (i_back.cm != r_bd);
        w_fch   = (i_front.cm != r_fd);
        case (i_req)
            REQ_MEASURE: begin
                if (w_bch) begin
                    n_bd = i_back.cm;
                    n_ba = i_back.alarm;
                    n_bt = i_back.tone;
                end
                if (w_fch) begin
                    n_fd = i_front.cm;
                    n_fa = i_front.alarm;
                    n_ft = i_front.tone;
                end
                if (w_bch || w_fch) begin
                    n_alb = n_ba;
                    n_alf = n_fa;
                    n_buz = n_ba | n_fa;
                end
                n_wa    = 1'b1;
                n_wc    = '0;
                n_bc    = '0;
                w_check = 1'b1;
            end
            REQ_TICK: begin
                if (r_wa) begin
                    n_wc = r_wc + 1'b1;
                    n_bc = r_bc + 1'b1;
                    if (n_wc > {1'b0, i_cfg.window_ticks}) begin
                        n_wa   = 1'b0;
                        w_done = 1'b1;
                    end else begin
                        w_check = 1'b1;
                    end
                end
            end
            REQ_STOP: begin
                n_alb = 1'b0;
                n_alf = 1'b0;
                n_buz = 1'b0;
                n_wa  = 1'b0;
                n_wc  = '0;
                n_bc  = '0;
            end
            default: begin
            end
        endcase

        // Toggle check against the period of the higher tone level.
        w_lvl    = (n_bt > n_ft) ? n_bt : n_ft;
        w_period = i_cfg.window_ticks >> w_lvl;
        if (w_check && (w_lvl >= TONE_BEEP_LO) && (w_lvl <= TONE_BEEP_HI)
                && (n_bc == {1'b0, w_period})) begin
            n_buz = ~n_buz;
            n_bc  = '0;
        end

        n_out.dist_back_cm  = n_bd;
        n_out.dist_front_cm = n_fd;
        n_out.alert_back    = n_alb;
        n_out.alert_front   = n_alf;
        n_out.buzzer_on     = n_buz;
        n_out.tone_level    = w_lvl;
        n_out.window_done   = w_done;
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bd  <= '0;
            r_fd  <= '0;
            r_bt  <= '0;
            r_ft  <= '0;
            r_ba  <= 1'b0;
            r_fa  <= 1'b0;
            r_alb <= 1'b0;
            r_alf <= 1'b0;
            r_buz <= 1'b0;
            r_wa  <= 1'b0;
            r_wc  <= '0;
            r_bc  <= '0;
        end else if (i_advance) begin
            r_bd  <= n_bd;
            r_fd  <= n_fd;
            r_bt  <= n_bt;
            r_ft  <= n_ft;
            r_ba  <= n_ba;
            r_fa  <= n_fa;
            r_alb <= n_alb;
            r_alf <= n_alf;
            r_buz <= n_buz;
            r_wa  <= n_wa;
            r_wc  <= n_wc;
            r_bc  <= n_bc;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_out <= n_out;
        end
    end

    assign o_result = r_out;

endmodule
`default_nettype wire

@@ design/ultrasonic_proximity_alarm_unit.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// ultrasonic_proximity_alarm_unit
// Two-sensor parking proximity alarm with alert lines and a beeping buzzer.
// ---------------------------------------------------------------------------
// The block takes one item per clock cycle while the output is not stalled
// and gives one result item for each via the lane and output registers. The
// back and front echoes are converted to centimetres by two lanes side by
// side in the first stage (one 15 by 16 bit multiply each); the second stage
// is a single state update that merges the lanes, runs the beep window and
// loads the output register, and it sets the rate of one item per cycle.
// Configuration is taken in any cycle and should be written while idle.
// ---------------------------------------------------------------------------
module ultrasonic_proximity_alarm_unit
    import upa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input items.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // Fields: back_rise[15:0], back_fall[31:16], front_rise[47:32],
    // front_fall[63:48].
    input  wire logic [63:0] i_s_tdata,
    // Fields: req_type[1:0].
    input  wire logic [1:0]  i_s_tuser,
    // Result items.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // Fields: dist_back_cm[9:0], dist_front_cm[19:10], alert_back[20],
    // alert_front[21], buzzer_on[22], tone_level[25:23], window_done[26].
    output logic [31:0]      o_m_tdata,
    // Configuration writes.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    logic               r_s1_valid;
    logic [1:0]         r_s1_req;
    logic               r_m_valid;
    logic               w_out_free;
    logic               w_advance;
    logic               w_load;
    logic [TICKS_W-1:0] r_window_ticks;
    logic [CM_W-1:0]    r_alarm_cm;
    t_lane_res          w_back, w_front;
    t_merge_cfg         w_cfg;
    t_result            w_result;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ticks <= WINDOW_TICKS_RST;
            r_alarm_cm     <= ALARM_CM_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WINDOW_TICKS: r_window_ticks <= i_cfg_data;
                CFG_ALARM_CM:     r_alarm_cm     <= i_cfg_data[CM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Pipeline handshake: the merge stage moves when the output is free.
    assign w_out_free = !r_m_valid || i_m_tready;
    assign w_advance  = r_s1_valid && w_out_free;
    assign o_s_tready = !r_s1_valid || w_advance;
    assign w_load     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_s1_valid <= i_s_tvalid;
            end
            if (w_out_free) begin
                r_m_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_s1_req <= i_s_tuser;
        end
    end

    // Sensor lanes.
    upa_echo_lane u_lane_back (
        .i_clk      (i_clk),
        .i_load     (w_load),
        .i_rise     (i_s_tdata[15:0]),
        .i_fall     (i_s_tdata[31:16]),
        .i_alarm_cm (r_alarm_cm),
        .o_res      (w_back)
    );

    upa_echo_lane u_lane_front (
        .i_clk      (i_clk),
        .i_load     (w_load),
        .i_rise     (i_s_tdata[47:32]),
        .i_fall     (i_s_tdata[63:48]),
        .i_alarm_cm (r_alarm_cm),
        .o_res      (w_front)
    );

    // Merging stage.
    assign w_cfg.window_ticks = r_window_ticks;

    upa_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_req     (r_s1_req),
        .i_back    (w_back),
        .i_front   (w_front),
        .i_cfg     (w_cfg),
        .o_result  (w_result)
    );

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {5'd0, w_result};

    // A staged item is never dropped while the output is stalled.
    a_stage_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_advance) |=> r_s1_valid)
        else $error("staged item lost while stalled");

    // The input is open to a new item only when the staged one moves on.
    a_ready_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_s_tready && r_s1_valid) |-> w_advance)
        else $error("input ready while the stage is blocked");

    // The reported tone level stays within its six bands.
    a_tone_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[25:23] <= 3'd5))
        else $error("tone level out of range");

    // A result appears only after the stage held an item.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_s1_valid))
        else $error("result without a staged item");

endmodule
`default_nettype wire
